### src/inode_permission_table_unit_defines.svh
// Assertion macros shared by the inode permission table RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef INODE_PERMISSION_TABLE_UNIT_DEFINES_SVH
`define INODE_PERMISSION_TABLE_UNIT_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define IPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define IPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/ipt_pkg.sv
// Types, codes and helpers for the inode permission table unit.
// No dependencies.
package ipt_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_CHMOD = 3'd2,
    OP_CHOWN = 3'd3,
    OP_CHECK = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_SCAN  = 2'd2,
    S_OUT   = 2'd3
  } state_e;

  // One table slot as stored in the memory.
  typedef struct packed {
    logic        used;
    logic [31:0] id;
    logic [8:0]  perm;
    logic [31:0] owner;
    logic [31:0] group;
  } entry_t;

  // Requested bits fit a three-bit rwx group.
  function automatic logic fits(input logic [8:0] want, input logic [2:0] have);
    return (want & {6'b0, have}) == want;
  endfunction

endpackage

### src/inode_permission_table_unit.sv
// Inode permission table: slot memory, sweep sequencer and result register.
// Depends on ipt_pkg and inode_permission_table_unit_defines.svh.
//
// A table of TABLE_SLOTS file entries in one single-port-read, one-port-write
// synchronous memory. One word is worked on at a time: after a word is taken
// the sequencer sweeps the slots from slot 0 upward, one read a cycle, and
// stops at the first free slot (allocate) or the first used slot whose id
// matches (free, chmod, chown, check), writing the modified entry back in the
// same cycle the hit is seen (check writes nothing). A bad id or unknown op is
// answered without a sweep: its result is offered right after the accepting
// edge. Otherwise the result is offered once the sweep reaches the hit or has
// read every slot (miss or full table); the single registered memory read port
// sets the pace of the sweep. The result sits in an output register until
// taken, and the block goes back to idle once it has gone and only then
// accepts the next word. After reset the block runs a clearing pass that
// marks every slot free; in_stall_o stays high during it.
`include "inode_permission_table_unit_defines.svh"

module inode_permission_table_unit #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] entry_id_i,
  input  logic [8:0]  mode_bits_i,
  input  logic [31:0] user_id_i,
  input  logic [31:0] group_id_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] new_id_o,
  output logic        allowed_o
);
  import ipt_pkg::*;

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(TABLE_SLOTS);
  localparam logic [31:0]      MAX_ID   = 32'(TABLE_SLOTS);

  // slot memory
  entry_t mem_q [TABLE_SLOTS];
  entry_t rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  // control
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;       // clear address, then sweep read address
  logic             rd_pend_q;          // rdata_q holds slot chk_idx_q
  logic [IDX_W-1:0] chk_idx_q;
  logic [31:0]      next_id_q, next_id_d;

  // captured word
  logic [2:0]  op_q;
  logic [31:0] id_q;
  logic [8:0]  mode_q;
  logic [31:0] uid_q;
  logic [31:0] gid_q;

  // result register
  stat_e       status_q, status_d;
  logic [31:0] new_id_q, new_id_d;
  logic        allowed_q, allowed_d;
  logic        res_ld;

  logic in_acc;
  logic bad_word;
  logic hit;
  logic miss_end;
  logic grant;

  assign in_acc = in_valid_i && !in_stall_o;

  // Unknown op, or a non-allocate id of zero or above TABLE_SLOTS, is answered without a sweep.
  assign bad_word = (operation_i > OP_CHECK) ||
                    ((operation_i != OP_ALLOC) &&
                     ((entry_id_i == 32'd0) || (entry_id_i > MAX_ID)));

  assign hit = rd_pend_q &&
               ((op_q == OP_ALLOC) ? !rdata_q.used
                                   : (rdata_q.used && (rdata_q.id == id_q)));
  assign miss_end = rd_pend_q && !hit && (chk_idx_q == LAST_IDX);

  // root, owner, group, other - in that order
  assign grant = (uid_q == 32'd0) ||
                 ((uid_q == rdata_q.owner) && fits(mode_q, rdata_q.perm[8:6])) ||
                 ((gid_q == rdata_q.group) && fits(mode_q, rdata_q.perm[5:3])) ||
                 fits(mode_q, rdata_q.perm[2:0]);

  assign mem_re    = (state_q == S_SCAN) && (cnt_q < SLOT_CNT);
  assign mem_raddr = cnt_q[IDX_W-1:0];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    next_id_d = next_id_q;
    mem_we    = 1'b0;
    mem_waddr = chk_idx_q;
    mem_wdata = rdata_q;
    res_ld    = 1'b0;
    status_d  = STAT_OK;
    new_id_d  = 32'd0;
    allowed_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = cnt_q[IDX_W-1:0];
        mem_wdata      = '0;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q[IDX_W-1:0] == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cnt_d = '0;
          if (bad_word) begin
            res_ld   = 1'b1;
            status_d = STAT_INVALID;
            state_d  = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (mem_re) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (hit) begin
          res_ld  = 1'b1;
          state_d = S_OUT;
          case (op_q)
            OP_ALLOC: begin
              mem_we          = 1'b1;
              mem_wdata.used  = 1'b1;
              mem_wdata.id    = next_id_q;
              mem_wdata.perm  = mode_q;
              mem_wdata.owner = uid_q;
              mem_wdata.group = gid_q;
              new_id_d        = next_id_q;
              next_id_d       = next_id_q + 32'd1;
            end
            OP_FREE: begin
              mem_we         = 1'b1;
              mem_wdata.used = 1'b0;
            end
            OP_CHMOD: begin
              mem_we         = 1'b1;
              mem_wdata.perm = mode_q;
            end
            OP_CHOWN: begin
              mem_we          = 1'b1;
              mem_wdata.owner = uid_q;
              mem_wdata.group = gid_q;
            end
            default: begin
              allowed_d = grant;
            end
          endcase
        end else if (miss_end) begin
          res_ld   = 1'b1;
          state_d  = S_OUT;
          status_d = (op_q == OP_ALLOC) ? STAT_FULL : STAT_NOT_FOUND;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      chk_idx_q <= '0;
      next_id_q <= 32'd1;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= mem_re;
      if (mem_re) begin
        chk_idx_q <= mem_raddr;
      end
      next_id_q <= next_id_d;
    end
  end

  // payload capture and result register, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= operation_i;
      id_q   <= entry_id_i;
      mode_q <= mode_bits_i;
      uid_q  <= user_id_i;
      gid_q  <= group_id_i;
    end
    if (res_ld) begin
      status_q  <= status_d;
      new_id_q  <= new_id_d;
      allowed_q <= allowed_d;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = status_q;
  assign new_id_o    = new_id_q;
  assign allowed_o   = allowed_q;

  `IPT_ASSERT_ALWAYS(a_one_word, out_valid_o |-> in_stall_o, "word taken with result pending")
  `IPT_ASSERT(a_we_scope, mem_we |-> (state_q == S_CLEAR || state_q == S_SCAN), "stray write")
  `IPT_ASSERT(a_allow_ok, (out_valid_o && allowed_o) |-> (status_o == STAT_OK), "bad grant")
  `IPT_ASSERT(a_id_on_ok, (out_valid_o && status_o != STAT_OK) |-> (new_id_o == 32'd0), "id")
  `IPT_ASSERT(a_id_step, (next_id_q != $past(next_id_q)) |-> $past(op_q == OP_ALLOC), "id step")

endmodule
